@@ src/bbn_pkg.sv @@
// Package with shared constants for the bounding box normalizer.
package bbn_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS = 16;
    localparam int NAXES = 3;
    localparam int OUT_W = 32;
    localparam int EXT_W = 17;
endpackage

@@ src/bbn_box.sv @@
// Per-axis minimum and maximum tracker for one lane of the bounding box.
module bbn_box #(
    parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          update,
    input  logic signed [COORD_WIDTH-1:0] pos,
    output logic signed [COORD_WIDTH-1:0] min_val,
    output logic signed [COORD_WIDTH-1:0] max_val
);
    import bbn_pkg::*;

    localparam logic signed [COORD_WIDTH-1:0] MostPos = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MostNeg = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] min_reg;
    logic signed [COORD_WIDTH-1:0] max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MostPos;
            max_reg <= MostNeg;
        end
        else if (clear)
        begin
            min_reg <= MostPos;
            max_reg <= MostNeg;
        end
        else if (update)
        begin
            if (pos < min_reg)
            begin
                min_reg <= pos;
            end
            if (pos > max_reg)
            begin
                max_reg <= pos;
            end
        end
    end

    assign min_val = min_reg;
    assign max_val = max_reg;
endmodule

@@ src/bbn_div_lane.sv @@
// Bit-serial restoring divider lane computing (num << 16) / den toward zero.
module bbn_div_lane #(
    parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH:0]   num,
    input  logic [COORD_WIDTH-1:0]        den,
    output logic                          done,
    output logic [bbn_pkg::OUT_W-1:0]     quotient
);
    import bbn_pkg::*;

    localparam int DW = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [COORD_WIDTH-1:0] rem_reg;
    logic [DW-1:0]          quo_reg;
    logic [COORD_WIDTH-1:0] den_reg;
    logic                   neg_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   done_reg;
    logic [COORD_WIDTH:0]   mag;
    logic [COORD_WIDTH:0]   shifted;
    logic [DW-1:0]          signed_q;

    assign mag = num[COORD_WIDTH] ? (~num + 1'b1) : num;
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign signed_q = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= {mag, {FRAC_BITS{1'b0}}};
            den_reg  <= den;
            neg_reg  <= num[COORD_WIDTH];
            cnt_reg  <= CW'(DW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_reg <= COORD_WIDTH'(shifted - {1'b0, den_reg});
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[COORD_WIDTH-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quotient = signed_q[OUT_W-1:0];
endmodule

@@ src/bounding_box_normalizer.sv @@
// Top level of the bounding box normalizer: vertex store, control and output merge.
// Load: one vertex per cycle, written to the store and box trackers while the store has room.
// After the last vertex, setup finds the box and longest span, then the extents when scaling.
// Each emitted vertex is then read from the store and divided by the bit-serial lane dividers,
// or not divided when normalization is off or the box is degenerate; no input during emit.
// Reset is asynchronous and active low; the vertex store is not cleared.
module bounding_box_normalizer #(
    parameter int MAX_VERTICES = bbn_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH = bbn_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [31:0]              pos_x,
    input  logic signed [31:0]              pos_y,
    input  logic signed [31:0]              pos_z,
    input  logic                            last_vertex,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [bbn_pkg::OUT_W-1:0] out_x,
    output logic signed [bbn_pkg::OUT_W-1:0] out_y,
    output logic signed [bbn_pkg::OUT_W-1:0] out_z,
    output logic signed [bbn_pkg::OUT_W-1:0] center_x,
    output logic signed [bbn_pkg::OUT_W-1:0] center_y,
    output logic signed [bbn_pkg::OUT_W-1:0] center_z,
    output logic [bbn_pkg::EXT_W-1:0]       extent_x,
    output logic [bbn_pkg::EXT_W-1:0]       extent_y,
    output logic [bbn_pkg::EXT_W-1:0]       extent_z,
    output logic                            degenerate,
    output logic                            last_result
);
    import bbn_pkg::*;

    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SW = NAXES * COORD_WIDTH;

    typedef enum logic [3:0] {
        S_LOAD, S_BOX, S_LEN, S_EXT, S_EXTW, S_READ, S_RDW, S_DIV, S_OUT
    } state_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    function automatic logic [OUT_W-1:0] fit32(input coord_t v);
        logic [COORD_WIDTH+OUT_W-1:0] w;
        w = {{OUT_W{v[COORD_WIDTH-1]}}, v};
        return w[OUT_W-1:0];
    endfunction

    state_t state_reg;
    logic   norm_reg;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] idx_reg;
    logic   box_clear;
    logic   lane_start_reg;
    logic   degen_reg;
    coord_t p_in [NAXES];
    coord_t min_v [NAXES];
    coord_t max_v [NAXES];
    logic [COORD_WIDTH-1:0] d_reg [NAXES];
    coord_t center_reg [NAXES];
    logic [COORD_WIDTH-1:0] len_reg;
    logic signed [COORD_WIDTH:0] lane_num_reg [NAXES];
    logic [NAXES-1:0] lane_done;
    logic [OUT_W-1:0] lane_q [NAXES];
    logic [EXT_W-1:0] ext_reg [NAXES];
    logic [OUT_W-1:0] out_v_reg [NAXES];
    logic [OUT_W-1:0] out_c_reg [NAXES];
    logic [EXT_W-1:0] out_e_reg [NAXES];
    logic   out_valid_reg;
    logic   out_degen_reg;
    logic   out_last_reg;
    logic   accept;
    logic   store_ok;
    logic [SW-1:0] mem [MAX_VERTICES];
    logic [SW-1:0] rd_data_reg;
    coord_t rd_p [NAXES];
    logic [COORD_WIDTH-1:0] len_next;

    generate
        if (COORD_WIDTH <= 32)
        begin : g_narrow
            assign p_in[0] = pos_x[COORD_WIDTH-1:0];
            assign p_in[1] = pos_y[COORD_WIDTH-1:0];
            assign p_in[2] = pos_z[COORD_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign p_in[0] = {{(COORD_WIDTH-32){1'b0}}, pos_x};
            assign p_in[1] = {{(COORD_WIDTH-32){1'b0}}, pos_y};
            assign p_in[2] = {{(COORD_WIDTH-32){1'b0}}, pos_z};
        end
    endgenerate

    assign in_stall = (state_reg != S_LOAD);
    assign accept = in_valid && !in_stall;
    assign store_ok = (count_reg < CNTW'(MAX_VERTICES));
    assign box_clear = ((state_reg == S_OUT) && !out_stall && out_last_reg)
                    || ((state_reg == S_LEN) && (count_reg == '0));

    genvar a;
    generate
        for (a = 0; a < NAXES; a++)
        begin : g_lane
            bbn_box #(.COORD_WIDTH(COORD_WIDTH)) u_box (
                .clk     (clk),
                .rst_n   (rst_n),
                .clear   (box_clear),
                .update  (accept && store_ok),
                .pos     (p_in[a]),
                .min_val (min_v[a]),
                .max_val (max_v[a])
            );
            bbn_div_lane #(.COORD_WIDTH(COORD_WIDTH)) u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (lane_start_reg),
                .num      (lane_num_reg[a]),
                .den      (len_reg),
                .done     (lane_done[a]),
                .quotient (lane_q[a])
            );
            assign rd_p[a] = rd_data_reg[a*COORD_WIDTH +: COORD_WIDTH];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            mem[count_reg[AW-1:0]] <= {p_in[2], p_in[1], p_in[0]};
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        len_next = d_reg[0];
        if (d_reg[1] > len_next)
        begin
            len_next = d_reg[1];
        end
        if (d_reg[2] > len_next)
        begin
            len_next = d_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            norm_reg       <= 1'b1;
            count_reg      <= '0;
            idx_reg        <= '0;
            lane_start_reg <= 1'b0;
            degen_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lane_start_reg <= 1'b0;
            if (cfg_we)
            begin
                norm_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (store_ok)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (last_vertex)
                        begin
                            state_reg <= S_BOX;
                        end
                    end
                end
                S_BOX:
                begin
                    for (int i = 0; i < NAXES; i++)
                    begin
                        d_reg[i] <= COORD_WIDTH'(max_v[i] - min_v[i]);
                        center_reg[i] <= min_v[i]
                            + coord_t'((COORD_WIDTH'(max_v[i] - min_v[i])) >> 1);
                    end
                    state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    len_reg   <= len_next;
                    degen_reg <= norm_reg && (len_next == '0);
                    idx_reg   <= '0;
                    for (int i = 0; i < NAXES; i++)
                    begin
                        ext_reg[i] <= '0;
                        lane_num_reg[i] <= {1'b0, d_reg[i]};
                    end
                    if (count_reg == '0)
                    begin
                        state_reg <= S_LOAD;
                    end
                    else if (norm_reg && (len_next != '0))
                    begin
                        state_reg <= S_EXT;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_EXT:
                begin
                    lane_start_reg <= 1'b1;
                    state_reg <= S_EXTW;
                end
                S_EXTW:
                begin
                    if (lane_done[0])
                    begin
                        for (int i = 0; i < NAXES; i++)
                        begin
                            ext_reg[i] <= lane_q[i][EXT_W-1:0];
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    out_degen_reg <= degen_reg;
                    out_last_reg  <= (idx_reg + 1'b1 == count_reg);
                    if (norm_reg && !degen_reg)
                    begin
                        for (int i = 0; i < NAXES; i++)
                        begin
                            lane_num_reg[i] <= {rd_p[i][COORD_WIDTH-1], rd_p[i]}
                                - {center_reg[i][COORD_WIDTH-1], center_reg[i]};
                        end
                        lane_start_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        for (int i = 0; i < NAXES; i++)
                        begin
                            out_v_reg[i] <= norm_reg ? '0 : fit32(rd_p[i]);
                            out_c_reg[i] <= '0;
                            out_e_reg[i] <= '0;
                        end
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (lane_done[0])
                    begin
                        for (int i = 0; i < NAXES; i++)
                        begin
                            out_v_reg[i] <= lane_q[i];
                            out_c_reg[i] <= fit32(center_reg[i]);
                            out_e_reg[i] <= ext_reg[i];
                        end
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_v_reg[0];
    assign out_y       = out_v_reg[1];
    assign out_z       = out_v_reg[2];
    assign center_x    = out_c_reg[0];
    assign center_y    = out_c_reg[1];
    assign center_z    = out_c_reg[2];
    assign extent_x    = out_e_reg[0];
    assign extent_y    = out_e_reg[1];
    assign extent_z    = out_e_reg[2];
    assign degenerate  = out_degen_reg;
    assign last_result = out_last_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (out_x == '0 && center_x == '0 && extent_x == '0))
        else $error("degenerate result carries nonzero data");

    a_pass_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !norm_reg) |-> (extent_y == '0 && center_y == '0 && !degenerate))
        else $error("pass-through result carries box data");

    a_ext_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (extent_z <= EXT_W'(1 << FRAC_BITS)))
        else $error("normalized extent above one");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done[0] |-> (state_reg == S_EXTW || state_reg == S_DIV))
        else $error("divider finished outside a divide phase");

    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_result) |=> (count_reg == '0 && !in_stall))
        else $error("box not cleared after final result");
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the bounding box normalizer: directed and random meshes.
`timescale 1ns / 1ps

module testbench;
    import bbn_pkg::*;

    localparam int NVERT = MAX_VERTICES_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } vertex_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] ox;
        logic signed [OUT_W-1:0] oy;
        logic signed [OUT_W-1:0] oz;
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic signed [OUT_W-1:0] cz;
        logic [EXT_W-1:0]        ex;
        logic [EXT_W-1:0]        ey;
        logic [EXT_W-1:0]        ez;
        logic                    degen;
        logic                    last;
    } norm_vertex_t;

    typedef struct {
        vertex_t      v;
        logic         fixed;
        norm_vertex_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic last_vertex = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] out_x, out_y, out_z, center_x, center_y, center_z;
    logic [EXT_W-1:0] extent_x, extent_y, extent_z;
    logic degenerate, last_result;

    bounding_box_normalizer i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last_vertex(last_vertex),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .extent_x(extent_x), .extent_y(extent_y), .extent_z(extent_z),
        .degenerate(degenerate), .last_result(last_result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state.
    logic signed [63:0] mesh_store [NVERT][3];
    logic signed [63:0] box_lo [3];
    logic signed [63:0] box_hi [3];
    int                 mesh_count;
    logic               scale_on;

    norm_vertex_t expected_q [$];
    norm_vertex_t pinned_q [$];
    logic         pinned_flag_q [$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_off = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic clear_box();
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = 64'sd2147483647;
            box_hi[a] = -64'sd2147483648;
        end
        mesh_count = 0;
    endtask

    function automatic logic signed [63:0] scaled_quotient(input logic signed [63:0] num,
                                                          input logic [63:0] den);
        logic        neg;
        logic [63:0] mag, q, r;
        neg = num < 0;
        mag = neg ? -num : num;
        q = mag / den;
        r = mag % den;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return neg ? -$signed(q) : $signed(q);
    endfunction

    task automatic predict_vertex(input vertex_t v, input logic fixed,
                                  input norm_vertex_t want);
        logic signed [63:0] p [3];
        logic signed [63:0] mid [3];
        logic [63:0]        span [3];
        logic [63:0]        longest;
        logic               degen;
        logic signed [63:0] ov [3];
        logic signed [63:0] oc [3];
        logic signed [63:0] oe [3];
        norm_vertex_t       r;
        p[0] = v.x;
        p[1] = v.y;
        p[2] = v.z;
        longest = 0;
        if (mesh_count < NVERT)
        begin
            for (int a = 0; a < 3; a++)
            begin
                mesh_store[mesh_count][a] = p[a];
                if (p[a] < box_lo[a]) box_lo[a] = p[a];
                if (p[a] > box_hi[a]) box_hi[a] = p[a];
            end
            mesh_count++;
        end
        if (!v.last) return;
        for (int a = 0; a < 3; a++)
        begin
            span[a] = (mesh_count > 0) ? box_hi[a] - box_lo[a] : 0;
            mid[a] = (mesh_count > 0) ? box_lo[a] + $signed(span[a] >> 1) : 0;
            if (span[a] > longest) longest = span[a];
        end
        degen = scale_on && longest == 0;
        for (int k = 0; k < mesh_count; k++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (!scale_on)
                begin
                    ov[a] = mesh_store[k][a];
                    oc[a] = 0;
                    oe[a] = 0;
                end
                else if (degen)
                begin
                    ov[a] = 0;
                    oc[a] = 0;
                    oe[a] = 0;
                end
                else
                begin
                    ov[a] = scaled_quotient(mesh_store[k][a] - mid[a], longest);
                    oc[a] = mid[a];
                    oe[a] = scaled_quotient($signed(span[a]), longest);
                end
            end
            r.ox = ov[0][31:0];
            r.oy = ov[1][31:0];
            r.oz = ov[2][31:0];
            r.cx = oc[0][31:0];
            r.cy = oc[1][31:0];
            r.cz = oc[2][31:0];
            r.ex = oe[0][EXT_W-1:0];
            r.ey = oe[1][EXT_W-1:0];
            r.ez = oe[2][EXT_W-1:0];
            r.degen = degen;
            r.last = (k + 1 == mesh_count);
            expected_q.insert(expected_q.size(), r);
        end
        // A directed row with a typed-in result pins its single emitted vertex.
        if (fixed)
        begin
            pinned_q.insert(pinned_q.size(), want);
            pinned_flag_q.insert(pinned_flag_q.size(), 1'b1);
        end
        else
        begin
            for (int k = 0; k < mesh_count; k++)
            begin
                pinned_q.insert(pinned_q.size(), want);
                pinned_flag_q.insert(pinned_flag_q.size(), 1'b0);
            end
        end
        clear_box();
    endtask

    // Sender side.
    vertex_t      send_q [$];
    logic         row_fixed_q [$];
    norm_vertex_t row_want_q [$];
    int           sent_count = 0;

    // Drives a vertex when none is pending or the current transfer completes, with random idle gaps.
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            predict_vertex(send_q[0], row_fixed_q[0], row_want_q[0]);
            void'(send_q.pop_front());
            void'(row_fixed_q.pop_front());
            void'(row_want_q.pop_front());
            sent_count++;
        end
        if (!in_valid || !in_stall)
        begin
            if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                pos_x <= send_q[0].x;
                pos_y <= send_q[0].y;
                pos_z <= send_q[0].z;
                last_vertex <= send_q[0].last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver side.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        norm_vertex_t e, pin;
        logic         pf;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("unexpected output transfer at %0t", $realtime);
                error_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                pin = pinned_q.pop_front();
                pf = pinned_flag_q.pop_front();
                if (pf && pin != e)
                begin
                    $display("predictor disagrees with directed table at %0t", $realtime);
                    error_count++;
                end
                if (out_x !== e.ox) report_mismatch("out_x", out_x, e.ox);
                if (out_y !== e.oy) report_mismatch("out_y", out_y, e.oy);
                if (out_z !== e.oz) report_mismatch("out_z", out_z, e.oz);
                if (center_x !== e.cx) report_mismatch("center_x", center_x, e.cx);
                if (center_y !== e.cy) report_mismatch("center_y", center_y, e.cy);
                if (center_z !== e.cz) report_mismatch("center_z", center_z, e.cz);
                if (extent_x !== e.ex) report_mismatch("extent_x", extent_x, e.ex);
                if (extent_y !== e.ey) report_mismatch("extent_y", extent_y, e.ey);
                if (extent_z !== e.ez) report_mismatch("extent_z", extent_z, e.ez);
                if (degenerate !== e.degen)
                    report_mismatch("degenerate", degenerate, e.degen);
                if (last_result !== e.last)
                    report_mismatch("last_result", last_result, e.last);
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_vertex(input vertex_t v, input logic fixed,
                                input norm_vertex_t want);
        send_q.insert(send_q.size(), v);
        row_fixed_q.insert(row_fixed_q.size(), fixed);
        row_want_q.insert(row_want_q.size(), want);
    endtask

    task automatic drain();
        wait (send_q.size() == 0 && expected_q.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_scale(input logic value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        scale_on = value;
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] random_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(65536 * 8)) - 65536 * 4;
            2: return $signed($urandom_range(400)) - 200;
            default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    task automatic random_mesh(input int nv);
        vertex_t      v;
        norm_vertex_t none;
        int           mode;
        none = '0;
        mode = $urandom_range(3);
        for (int i = 0; i < nv; i++)
        begin
            v.x = ($urandom_range(9) == 0) ? random_coord($urandom_range(3)) : random_coord(mode);
            v.y = random_coord(mode);
            v.z = ($urandom_range(7) == 0) ? v.x : random_coord(mode);
            v.last = (i == nv - 1);
            queue_vertex(v, 1'b0, none);
        end
    endtask

    stim_row_t    directed [$];
    stim_row_t    row;
    norm_vertex_t z;
    int           budget;

    initial
    begin
        z = '0;
        scale_on = 1'b1;
        clear_box();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single vertex mesh with extreme coordinates: degenerate box.
        row.fixed = 1'b1;
        row.v = '{32'sh7fffffff, 32'sh80000000, 32'sh00010000, 1'b1};
        row.want = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1};
        directed.insert(directed.size(), row);
        foreach (directed[i]) queue_vertex(directed[i].v, directed[i].fixed, directed[i].want);
        directed.delete();
        // Two-vertex mesh over the full range with exact results.
        row.fixed = 1'b0;
        row.want = z;
        row.v = '{32'sh80000000, 32'sh80000000, 32'sh0, 1'b0};
        directed.insert(directed.size(), row);
        row.v = '{32'sh7fffffff, 32'sh0, 32'sh0, 1'b1};
        directed.insert(directed.size(), row);
        row.v = '{32'sh00020000, -32'sh00020000, 32'sh1, 1'b0};
        directed.insert(directed.size(), row);
        row.v = '{-32'sh00020000, 32'sh00020000, -32'sh1, 1'b0};
        directed.insert(directed.size(), row);
        row.v = '{32'sh5555, 32'shAAAA, 32'sh12345678, 1'b1};
        directed.insert(directed.size(), row);
        foreach (directed[i]) queue_vertex(directed[i].v, directed[i].fixed, directed[i].want);
        drain();

        write_scale(1'b0);
        row.fixed = 1'b1;
        row.v = '{32'sh7fffffff, 32'sh80000000, -32'sh1, 1'b1};
        row.want = '{32'sh7fffffff, 32'sh80000000, -32'sh1, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1};
        queue_vertex(row.v, row.fixed, row.want);
        random_mesh(5);
        drain();
        write_scale(1'b1);

        // Store full: the vertices past the store size are dropped.
        random_mesh(NVERT + 3);
        drain();

        budget = 270 - 70;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? 48 : 0;
            recv_stall_pct = (phase == 2) ? 48 : (phase == 3 ? 17 : 0);
            if (phase == 3) send_idle_pct = 17;
            if (phase == 2) hold_off = 300;
            for (int m = 0; m < 4; m++)
            begin
                int nv;
                nv = $urandom_range(12, 1);
                random_mesh(nv);
                budget -= nv;
            end
            if (phase == 1)
            begin
                drain();
                write_scale(1'b0);
                random_mesh(8);
                drain();
                write_scale(1'b1);
            end
        end
        while (budget > 0)
        begin
            int nv;
            nv = $urandom_range(10, 1);
            random_mesh(nv);
            budget -= nv;
        end
        drain();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
